@@ hw/rtl/rtc_cmp_pkg.sv @@
package rtc_cmp_pkg;

    localparam int NUM_COMPARE_DEFAULT = 12;

    // item function codes
    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // register offsets
    localparam logic [11:0] OFF_START    = 12'h060;
    localparam logic [11:0] OFF_STOP     = 12'h064;
    localparam logic [11:0] OFF_CLEAR    = 12'h068;
    localparam logic [11:0] OFF_EVENTS   = 12'h100;
    localparam logic [11:0] OFF_PUBLISH  = 12'h180;
    localparam logic [11:0] OFF_INTEN    = 12'h300;
    localparam logic [11:0] OFF_INTENSET = 12'h304;
    localparam logic [11:0] OFF_INTENCLR = 12'h308;
    localparam logic [11:0] OFF_INTPEND  = 12'h30C;
    localparam logic [11:0] OFF_CC       = 12'h520;
    localparam logic [11:0] OFF_CNT_LOW  = 12'h720;
    localparam logic [11:0] OFF_CNT_HIGH = 12'h724;
    localparam logic [11:0] OFF_CAPTURE  = 12'h748;

    // sub-offsets inside one compare channel row
    localparam logic [3:0] CC_SUB_LOW    = 4'h0;
    localparam logic [3:0] CC_SUB_HIGH   = 4'h4;
    localparam logic [3:0] CC_SUB_RELCNT = 4'h8;
    localparam logic [3:0] CC_SUB_ENABLE = 4'hC;

    localparam logic [31:0] TASK_TRIGGER = 32'd1;
    localparam int          PUB_ENABLE_BIT = 31;
    localparam logic [31:0] LOADED_MASK    = 32'h8000_0000;

endpackage

@@ hw/rtl/realtime_counter_compare_unit.sv @@
// Register-mapped 64-bit tick counter with NUM_COMPARE one-shot relative compare
// channels. Each item is a bus read, a bus write or one counter tick, and gives
// exactly one result. Every item is handled in the cycle it is accepted: all
// channels and the counter update in parallel, and the result is registered,
// so a new item can be taken every cycle while in_ready is high. A two-entry
// output buffer (result register plus skid register) keeps input accepting
// while one result waits; in_ready drops only when both entries hold untaken
// results.
module realtime_counter_compare_unit #(
    parameter int NUM_COMPARE = rtc_cmp_pkg::NUM_COMPARE_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             func,
    input  logic [11:0]            offset,
    input  logic [31:0]            write_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [31:0]            read_data,
    output logic [NUM_COMPARE-1:0] fired_mask,
    output logic                   irq_pulse,
    output logic [31:0]            publish_mask
);

    localparam logic [9:0] EVT_WORD = rtc_cmp_pkg::OFF_EVENTS[11:2];
    localparam logic [9:0] PUB_WORD = rtc_cmp_pkg::OFF_PUBLISH[11:2];
    localparam logic [7:0] CC_ROW   = rtc_cmp_pkg::OFF_CC[11:4];

    // counter and global state
    logic [63:0] tick_reg, tick_next;
    logic        running_reg, running_next;
    logic [31:0] cap_low_reg, cap_low_next;
    logic [31:0] cap_high_reg, cap_high_next;
    logic [31:0] irq_en_reg, irq_en_next;

    // per-channel state
    logic [NUM_COMPARE-1:0] flag_reg, flag_next;
    logic [NUM_COMPARE-1:0] enable_reg, enable_next;
    logic [NUM_COMPARE-1:0] armed_reg, armed_next;
    logic [31:0] route_reg [NUM_COMPARE];
    logic [31:0] route_next [NUM_COMPARE];
    logic [31:0] cmp_low_reg [NUM_COMPARE];
    logic [31:0] cmp_low_next [NUM_COMPARE];
    logic [31:0] cmp_high_reg [NUM_COMPARE];
    logic [31:0] cmp_high_next [NUM_COMPARE];
    logic [31:0] relcnt_reg [NUM_COMPARE];
    logic [31:0] relcnt_next [NUM_COMPARE];
    logic [31:0] remain_reg [NUM_COMPARE];
    logic [31:0] remain_next [NUM_COMPARE];

    // output buffer
    logic                   out_valid_reg, skid_valid_reg;
    logic [31:0]            out_rd_reg, skid_rd_reg;
    logic [NUM_COMPARE-1:0] out_fired_reg, skid_fired_reg;
    logic                   out_irq_reg, skid_irq_reg;
    logic [31:0]            out_pub_reg, skid_pub_reg;

    logic                   accept;
    logic                   pop;
    logic [31:0]            read_value;
    logic [31:0]            res_rd;
    logic [NUM_COMPARE-1:0] res_fired;
    logic                   res_irq;
    logic [31:0]            res_pub;
    logic [63:0]            live_count;
    logic                   cap_held;
    logic [31:0]            pending;

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;
    assign pop      = out_valid_reg && out_ready;

    assign live_count = running_reg ? tick_reg : 64'd0;
    assign cap_held   = (cap_low_reg != 32'd0) || (cap_high_reg != 32'd0);

    always_comb
    begin
        pending = '0;
        for (int n = 0; n < NUM_COMPARE; n++)
        begin
            pending[n] = flag_reg[n] & irq_en_reg[n];
        end
    end

    // register read mux; channel windows never overlap the fixed registers
    always_comb
    begin
        case (offset)
            rtc_cmp_pkg::OFF_CNT_LOW:
                read_value = cap_held ? cap_low_reg : live_count[31:0];
            rtc_cmp_pkg::OFF_CNT_HIGH:
                read_value = (cap_held ? cap_high_reg : live_count[63:32])
                             | rtc_cmp_pkg::LOADED_MASK;
            rtc_cmp_pkg::OFF_CAPTURE:
                read_value = 32'd1;
            rtc_cmp_pkg::OFF_INTEN, rtc_cmp_pkg::OFF_INTENSET:
                read_value = irq_en_reg;
            rtc_cmp_pkg::OFF_INTPEND:
                read_value = pending;
            default:
                read_value = '0;
        endcase
        for (int n = 0; n < NUM_COMPARE; n++)
        begin
            if (offset[11:2] == EVT_WORD + 10'(n))
            begin
                read_value = {31'd0, flag_reg[n]};
            end
            if (offset[11:2] == PUB_WORD + 10'(n))
            begin
                read_value = route_reg[n];
            end
            if (offset[11:4] == CC_ROW + 8'(n))
            begin
                case (offset[3:0])
                    rtc_cmp_pkg::CC_SUB_LOW:    read_value = cmp_low_reg[n];
                    rtc_cmp_pkg::CC_SUB_HIGH:   read_value = cmp_high_reg[n];
                    rtc_cmp_pkg::CC_SUB_RELCNT: read_value = relcnt_reg[n];
                    rtc_cmp_pkg::CC_SUB_ENABLE: read_value = {31'd0, enable_reg[n]};
                    default:                    read_value = '0;
                endcase
            end
        end
    end

    // next state and result for the accepted item
    always_comb
    begin
        tick_next     = tick_reg;
        running_next  = running_reg;
        cap_low_next  = cap_low_reg;
        cap_high_next = cap_high_reg;
        irq_en_next   = irq_en_reg;
        flag_next     = flag_reg;
        enable_next   = enable_reg;
        armed_next    = armed_reg;
        route_next    = route_reg;
        cmp_low_next  = cmp_low_reg;
        cmp_high_next = cmp_high_reg;
        relcnt_next   = relcnt_reg;
        remain_next   = remain_reg;
        res_rd        = '0;
        res_fired     = '0;
        res_irq       = 1'b0;
        res_pub       = '0;

        if (accept)
        begin
            case (func)
                rtc_cmp_pkg::FUNC_READ:
                begin
                    res_rd = read_value;
                end
                rtc_cmp_pkg::FUNC_WRITE:
                begin
                    for (int n = 0; n < NUM_COMPARE; n++)
                    begin
                        if (offset[11:2] == EVT_WORD + 10'(n))
                        begin
                            flag_next[n] = write_data[0];
                        end
                        if (offset[11:2] == PUB_WORD + 10'(n))
                        begin
                            route_next[n] = write_data;
                        end
                        if (offset[11:4] == CC_ROW + 8'(n))
                        begin
                            case (offset[3:0])
                                rtc_cmp_pkg::CC_SUB_LOW:    cmp_low_next[n] = write_data;
                                rtc_cmp_pkg::CC_SUB_HIGH:   cmp_high_next[n] = write_data;
                                rtc_cmp_pkg::CC_SUB_RELCNT: relcnt_next[n] = write_data;
                                rtc_cmp_pkg::CC_SUB_ENABLE:
                                begin
                                    enable_next[n] = write_data[0];
                                    if (write_data[0] && running_reg)
                                    begin
                                        remain_next[n] = relcnt_reg[n];
                                        armed_next[n]  = 1'b1;
                                    end
                                    else if (!write_data[0])
                                    begin
                                        armed_next[n] = 1'b0;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                    case (offset)
                        rtc_cmp_pkg::OFF_START:
                        begin
                            if (write_data == rtc_cmp_pkg::TASK_TRIGGER)
                            begin
                                running_next = 1'b1;
                                tick_next    = '0;
                                for (int n = 0; n < NUM_COMPARE; n++)
                                begin
                                    if (enable_reg[n])
                                    begin
                                        remain_next[n] = relcnt_reg[n];
                                        armed_next[n]  = 1'b1;
                                    end
                                end
                            end
                        end
                        rtc_cmp_pkg::OFF_STOP:
                        begin
                            if (write_data == rtc_cmp_pkg::TASK_TRIGGER)
                            begin
                                running_next = 1'b0;
                                armed_next   = '0;
                            end
                        end
                        rtc_cmp_pkg::OFF_CLEAR:
                        begin
                            if (write_data == rtc_cmp_pkg::TASK_TRIGGER)
                            begin
                                tick_next = '0;
                            end
                        end
                        rtc_cmp_pkg::OFF_CAPTURE:
                        begin
                            if (write_data == rtc_cmp_pkg::TASK_TRIGGER)
                            begin
                                cap_low_next  = live_count[31:0];
                                cap_high_next = live_count[63:32];
                            end
                            else
                            begin
                                cap_low_next  = '0;
                                cap_high_next = '0;
                            end
                        end
                        rtc_cmp_pkg::OFF_INTEN:    irq_en_next = write_data;
                        rtc_cmp_pkg::OFF_INTENSET: irq_en_next = irq_en_reg | write_data;
                        rtc_cmp_pkg::OFF_INTENCLR: irq_en_next = irq_en_reg & ~write_data;
                        default: ;
                    endcase
                end
                rtc_cmp_pkg::FUNC_TICK:
                begin
                    if (running_reg)
                    begin
                        tick_next = tick_reg + 64'd1;
                        for (int n = 0; n < NUM_COMPARE; n++)
                        begin
                            if (armed_reg[n])
                            begin
                                if (remain_reg[n] > 32'd1)
                                begin
                                    remain_next[n] = remain_reg[n] - 32'd1;
                                end
                                else
                                begin
                                    // one-shot expiry, enable stays set
                                    remain_next[n] = '0;
                                    armed_next[n]  = 1'b0;
                                    flag_next[n]   = 1'b1;
                                    res_fired[n]   = 1'b1;
                                    if (irq_en_reg[n])
                                    begin
                                        res_irq = 1'b1;
                                    end
                                    if (route_reg[n][rtc_cmp_pkg::PUB_ENABLE_BIT])
                                    begin
                                        res_pub = res_pub | (32'd1 << route_reg[n][4:0]);
                                    end
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= '0;
            running_reg  <= 1'b0;
            cap_low_reg  <= '0;
            cap_high_reg <= '0;
            irq_en_reg   <= '0;
            flag_reg     <= '0;
            enable_reg   <= '0;
            armed_reg    <= '0;
            for (int n = 0; n < NUM_COMPARE; n++)
            begin
                route_reg[n]    <= '0;
                cmp_low_reg[n]  <= '0;
                cmp_high_reg[n] <= '0;
                relcnt_reg[n]   <= '0;
                remain_reg[n]   <= '0;
            end
        end
        else
        begin
            tick_reg     <= tick_next;
            running_reg  <= running_next;
            cap_low_reg  <= cap_low_next;
            cap_high_reg <= cap_high_next;
            irq_en_reg   <= irq_en_next;
            flag_reg     <= flag_next;
            enable_reg   <= enable_next;
            armed_reg    <= armed_next;
            route_reg    <= route_next;
            cmp_low_reg  <= cmp_low_next;
            cmp_high_reg <= cmp_high_next;
            relcnt_reg   <= relcnt_next;
            remain_reg   <= remain_next;
        end
    end

    // output buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (pop)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (accept)
            begin
                if (out_valid_reg && !out_ready)
                begin
                    skid_valid_reg <= 1'b1;
                end
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output buffer payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_rd_reg    <= skid_rd_reg;
                out_fired_reg <= skid_fired_reg;
                out_irq_reg   <= skid_irq_reg;
                out_pub_reg   <= skid_pub_reg;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_rd_reg    <= res_rd;
                skid_fired_reg <= res_fired;
                skid_irq_reg   <= res_irq;
                skid_pub_reg   <= res_pub;
            end
            else
            begin
                out_rd_reg    <= res_rd;
                out_fired_reg <= res_fired;
                out_irq_reg   <= res_irq;
                out_pub_reg   <= res_pub;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = out_rd_reg;
    assign fired_mask   = out_fired_reg;
    assign irq_pulse    = out_irq_reg;
    assign publish_mask = out_pub_reg;

    a_skid_implies_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a head result");

    a_armed_only_running: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> (armed_reg == '0))
        else $error("channel armed while counter stopped");

    a_fired_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_fired_reg != '0)) |-> (out_rd_reg == 32'd0))
        else $error("tick result carries read data");

    a_irq_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_irq_reg) |-> (out_fired_reg != '0))
        else $error("irq pulse without an expiring channel");

    a_full_holds_off: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("buffered item lost while output stalled");

endmodule
